// ----- sv/scd_pkg.sv -----
// shared types and constants for the serial check digit block
// no dependencies
`timescale 1ns / 1ps

package scd_pkg;

  localparam int CHAR_W  = 8;
  localparam int CRC_W   = 16;
  localparam int DIGIT_W = 4;

  localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h8005;
  localparam logic [CRC_W-1:0]  CRC_SEED   = 16'h0000;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic [5:0] check_char;
    logic [1:0] group_index;
    logic       is_verdict;
    logic       match;
    logic       last;
  } result_t;

endpackage

// ----- sv/serial_check_digit_crc16_core.sv -----
// top level of the serial check digit block: request registers, mode register, result register
// depends on scd_pkg, scd_seq and scd_crc
`timescale 1ns / 1ps

// Serial check digit core.
// Input channel (in_valid/in_ready) takes one serial byte per request with
// start_req marking the first byte of a new serial. Each group of GROUP_LEN
// bytes runs through a crc-16 (0x8005, init 0, msb first); the crc modulo ten
// is the group's check digit.
// Mode (cfg_valid/cfg_ready, data on mode) must be written while the core is
// idle; the core does not enforce this. 0 emits one ascii digit per group, the
// last one flagged, 1 compares the GROUPS characters after the body with the
// digits and emits one verdict. Output channel (out_valid/out_ready) carries
// at most one result per request. Timing: a request waits in an input register
// until the result register is free or being taken, then the crc update, digit
// and decision settle in one pass into the result register. Throughput is one
// request per cycle while the receiver keeps up, set by the single-pass crc
// unit. When the receiver stalls, a held result blocks only the next request
// that is in the input register; in_ready drops once both registers are full.
// Reset clears position, crc, mode and both valid flags; no clearing pass.
module serial_check_digit_crc16_core import scd_pkg::*; #(
  parameter int GROUP_LEN = 4,
  parameter int GROUPS    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] serial_char,
  input  logic              start_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        check_char,
  output logic [1:0]        group_index,
  output logic              is_verdict,
  output logic              match,
  output logic              last
);

  logic              cur_mode;
  logic              held_valid;
  logic [CHAR_W-1:0] held_char;
  logic              held_start;
  logic              adv;
  logic              res_valid;
  result_t           res;
  result_t           res_q;

  assign cfg_ready = 1'b1;
  assign adv       = held_valid && (!out_valid || out_ready);
  assign in_ready  = !held_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode <= 1'b0;
    end else if (cfg_valid) begin
      cur_mode <= mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_char  <= serial_char;
      held_start <= start_req;
    end
  end

  scd_seq #(
    .GROUP_LEN (GROUP_LEN),
    .GROUPS    (GROUPS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .mode        (cur_mode),
    .step        (adv),
    .serial_char (held_char),
    .start_req   (held_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_q <= res;
    end
  end

  assign check_char  = res_q.check_char;
  assign group_index = res_q.group_index;
  assign is_verdict  = res_q.is_verdict;
  assign match       = res_q.match;
  assign last        = res_q.last;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_verdict |-> check_char >= 6'd48 && check_char <= 6'd57 && !match)
    else $error("generated digit out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_verdict |-> last && check_char == 6'd0 && group_index == 2'd0)
    else $error("malformed verdict");

  assert property (@(posedge clk) disable iff (rst)
    held_valid && !adv |=> held_valid && $stable(held_char) && $stable(held_start))
    else $error("held request lost while stalled");

  assert property (@(posedge clk)
    rst |=> !out_valid && !held_valid)
    else $error("valid flags not cleared by reset");

endmodule

// ----- sv/scd_crc.sv -----
// one-byte crc-16 update (poly 0x8005, msb first) and decimal digit of the result
// depends on scd_pkg
`timescale 1ns / 1ps

module scd_crc import scd_pkg::*; (
  input  logic [CRC_W-1:0]   crc_in,
  input  logic [CHAR_W-1:0]  data,
  output logic [CRC_W-1:0]   crc_out,
  output logic [DIGIT_W-1:0] digit
);

  localparam logic [16:0] RECIP_10 = 17'd52429;
  localparam int          RECIP_SH = 19;

  logic [CRC_W-1:0] crc_bits;
  logic [32:0]      prod;
  logic [13:0]      quot;
  logic [CRC_W-1:0] rem_full;

  always_comb begin
    crc_bits = crc_in;
    for (int b = CHAR_W - 1; b >= 0; b--) begin
      if (crc_bits[CRC_W-1] ^ data[b]) begin
        crc_bits = {crc_bits[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc_bits = {crc_bits[CRC_W-2:0], 1'b0};
      end
    end
  end

  assign crc_out = crc_bits;

  // divide by ten via reciprocal, exact for every 16-bit value
  assign prod     = 33'(crc_bits) * 33'(RECIP_10);
  assign quot     = prod[RECIP_SH+13:RECIP_SH];
  assign rem_full = crc_bits - CRC_W'(quot) * CRC_W'(10);
  assign digit    = rem_full[DIGIT_W-1:0];

endmodule

// ----- sv/scd_seq.sv -----
// position counters, running crc, stored check digits and result decision
// depends on scd_pkg and scd_crc
`timescale 1ns / 1ps

module scd_seq import scd_pkg::*; #(
  parameter int GROUP_LEN = 4,
  parameter int GROUPS    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              mode,
  input  logic              step,
  input  logic [CHAR_W-1:0] serial_char,
  input  logic              start_req,
  output logic              res_valid,
  output result_t           res
);

  localparam int BYTE_W = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;
  localparam int GRP_W  = $clog2(GROUPS + 1);
  localparam int IDX_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam logic [BYTE_W-1:0] BYTE_END = BYTE_W'(GROUP_LEN - 1);
  localparam logic [GRP_W-1:0]  GRP_LAST = GRP_W'(GROUPS - 1);
  localparam logic [GRP_W-1:0]  GRP_NUM  = GRP_W'(GROUPS);

  logic [CRC_W-1:0]   crc_reg, crc_next, crc_base, crc_upd;
  logic [BYTE_W-1:0]  byte_cnt, byte_cnt_next, byte_base;
  logic [GRP_W-1:0]   grp_cnt, grp_cnt_next, grp_base;
  logic [GRP_W-1:0]   chk_cnt, chk_cnt_next, chk_base;
  logic               mismatch_seen, mismatch_seen_next, mis_base;
  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] check_digits [GROUPS];
  logic               digit_wr;
  logic [CHAR_W-1:0]  expect_char;

  assign crc_base  = start_req ? CRC_SEED : crc_reg;
  assign byte_base = start_req ? '0 : byte_cnt;
  assign grp_base  = start_req ? '0 : grp_cnt;
  assign chk_base  = start_req ? '0 : chk_cnt;
  assign mis_base  = start_req ? 1'b0 : mismatch_seen;

  scd_crc u_crc (
    .crc_in  (crc_base),
    .data    (serial_char),
    .crc_out (crc_upd),
    .digit   (digit)
  );

  assign expect_char = ASCII_ZERO + CHAR_W'(check_digits[chk_base[IDX_W-1:0]]);

  always_comb begin
    crc_next           = crc_base;
    byte_cnt_next      = byte_base;
    grp_cnt_next       = grp_base;
    chk_cnt_next       = chk_base;
    mismatch_seen_next = mis_base;
    digit_wr           = 1'b0;
    res_valid          = 1'b0;
    res                = '0;
    if (grp_base < GRP_NUM) begin
      if (byte_base == BYTE_END) begin
        crc_next      = CRC_SEED;
        byte_cnt_next = '0;
        grp_cnt_next  = grp_base + 1'b1;
        digit_wr      = 1'b1;
        res_valid     = !mode;
        res.check_char  = 6'(ASCII_ZERO + CHAR_W'(digit));
        res.group_index = 2'(grp_base);
        res.last        = (grp_base == GRP_LAST);
      end else begin
        crc_next      = crc_upd;
        byte_cnt_next = byte_base + 1'b1;
      end
    end else if (mode && chk_base < GRP_NUM) begin
      mismatch_seen_next = mis_base | (serial_char != expect_char);
      chk_cnt_next       = chk_base + 1'b1;
      res_valid          = (chk_base == GRP_LAST);
      res.is_verdict     = 1'b1;
      res.match          = !mismatch_seen_next;
      res.last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg       <= CRC_SEED;
      byte_cnt      <= '0;
      grp_cnt       <= '0;
      chk_cnt       <= '0;
      mismatch_seen <= 1'b0;
    end else if (step) begin
      crc_reg       <= crc_next;
      byte_cnt      <= byte_cnt_next;
      grp_cnt       <= grp_cnt_next;
      chk_cnt       <= chk_cnt_next;
      mismatch_seen <= mismatch_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && digit_wr) begin
      check_digits[grp_base[IDX_W-1:0]] <= digit;
    end
  end

  // check part is only entered once every body group is closed
  assert property (@(posedge clk) disable iff (rst)
    chk_cnt != '0 |-> grp_cnt == GRP_NUM)
    else $error("check count advanced before body complete");

  assert property (@(posedge clk) disable iff (rst)
    step && digit_wr |=> byte_cnt == '0 && crc_reg == CRC_SEED)
    else $error("group close did not restart crc");

  assert property (@(posedge clk) disable iff (rst)
    grp_cnt <= GRP_NUM && chk_cnt <= GRP_NUM)
    else $error("position counters out of range");

endmodule

// ----- tb/tb_serial_check_digit_crc16_core.sv -----
// self-checking testbench for serial_check_digit_crc16_core: crc-16 check digits and verdicts
// depends on scd_pkg and the core; predicts each result when its request is accepted
`timescale 1ns / 1ps

module tb_serial_check_digit_crc16_core;
  import scd_pkg::*;

  localparam int GROUP_LEN    = 4;
  localparam int GROUPS       = 4;
  localparam int BODY_CHARS   = GROUP_LEN * GROUPS;
  localparam int SERIAL_CHARS = BODY_CHARS + GROUPS;

  localparam logic MODE_GENERATE = 1'b0;
  localparam logic MODE_VERIFY   = 1'b1;

  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 8;

  // all-zero group, all-ones group, msb/lsb patterns, ascii group
  localparam logic [BODY_CHARS*CHAR_W-1:0] EDGE_BODY =
    128'h00000000_FFFFFFFF_807F01FE_3039417A;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              first;
  } serial_req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_mode = MODE_GENERATE;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] serial_char = '0;
  logic              start_req = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [5:0]        check_char;
  logic [1:0]        group_index;
  logic              is_verdict;
  logic              match;
  logic              last;

  serial_req_t serial_reqs[$];
  result_t     awaited_digits[$];
  serial_req_t next_req;
  result_t     want;

  int   errors = 0;
  int   accepted_reqs = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_off = 1'b0;

  // predictor state
  logic [4:0]  serial_pos;
  logic [15:0] group_crc;
  logic [3:0]  group_digit [GROUPS];
  logic        digit_miss;
  logic        model_mode;

  serial_check_digit_crc16_core #(
    .GROUP_LEN(GROUP_LEN),
    .GROUPS(GROUPS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .mode(cfg_mode),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .serial_char(serial_char),
    .start_req(start_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .check_char(check_char),
    .group_index(group_index),
    .is_verdict(is_verdict),
    .match(match),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [CHAR_W-1:0] ch);
    logic [15:0] c;
    c = crc;
    for (int b = CHAR_W - 1; b >= 0; b--)
      c = {c[14:0], 1'b0} ^ ((c[15] ^ ch[b]) ? CRC_POLY : 16'h0000);
    return c;
  endfunction

  task automatic predict_char(input logic [CHAR_W-1:0] ch, input logic first);
    result_t res;
    int      g;
    int      k;
    res = '0;
    if (first) begin
      serial_pos = '0;
      group_crc  = CRC_SEED;
      digit_miss = 1'b0;
    end
    if (serial_pos < BODY_CHARS) begin
      group_crc = crc16_step(group_crc, ch);
      if (serial_pos % GROUP_LEN == GROUP_LEN - 1) begin
        g = serial_pos / GROUP_LEN;
        group_digit[g] = 4'(group_crc % 10);
        group_crc = CRC_SEED;
        if (model_mode == MODE_GENERATE) begin
          res.check_char  = 6'(ASCII_ZERO + group_digit[g]);
          res.group_index = 2'(g);
          res.last        = (g == GROUPS - 1);
          awaited_digits.push_back(res);
        end
      end
      serial_pos++;
    end else if (model_mode == MODE_VERIFY && serial_pos < SERIAL_CHARS) begin
      k = serial_pos - BODY_CHARS;
      if (ch != ASCII_ZERO + group_digit[k])
        digit_miss = 1'b1;
      serial_pos++;
      if (k == GROUPS - 1) begin
        res.is_verdict = 1'b1;
        res.match      = !digit_miss;
        res.last       = 1'b1;
        awaited_digits.push_back(res);
      end
    end
  endtask

  function automatic logic [CHAR_W-1:0] random_char();
    case ($urandom_range(3))
      0: return CHAR_W'(ASCII_ZERO + $urandom_range(9));
      1: return CHAR_W'($urandom_range(8'h41, 8'h5a));
      default: return CHAR_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] spoil_char(input logic [CHAR_W-1:0] good);
    logic [CHAR_W-1:0] c;
    if ($urandom_range(1)) begin
      c = CHAR_W'(ASCII_ZERO + (good - ASCII_ZERO + 1 + $urandom_range(8)) % 10);
    end else begin
      do c = CHAR_W'($urandom_range(255)); while (c == good);
    end
    return c;
  endfunction

  // body chars with start on the first, then check chars, then loose chars
  task automatic queue_serial(input int body_len, input int n_checks, input bit corrupt,
                              input int extra);
    logic [CHAR_W-1:0] body_ch;
    logic [CHAR_W-1:0] good_ch;
    logic [15:0]       crc;
    logic [3:0]        digit [GROUPS];
    int                bad;
    crc = CRC_SEED;
    bad = (corrupt && n_checks > 0) ? int'($urandom_range(n_checks - 1)) : -1;
    for (int i = 0; i < BODY_CHARS; i++) begin
      body_ch = random_char();
      crc = crc16_step(crc, body_ch);
      if (i % GROUP_LEN == GROUP_LEN - 1) begin
        digit[i / GROUP_LEN] = 4'(crc % 10);
        crc = CRC_SEED;
      end
      if (i < body_len)
        serial_reqs.push_back('{ch: body_ch, first: (i == 0)});
    end
    for (int k = 0; k < n_checks; k++) begin
      good_ch = CHAR_W'(ASCII_ZERO + digit[k]);
      serial_reqs.push_back('{ch: (k == bad) ? spoil_char(good_ch) : good_ch, first: 1'b0});
    end
    repeat (extra)
      serial_reqs.push_back('{ch: CHAR_W'($urandom_range(255)), first: 1'b0});
  endtask

  task automatic write_mode(input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_mode  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_mode = value;
  endtask

  task automatic wait_drained();
    while (serial_reqs.size() != 0 || in_valid || awaited_digits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic compare_field(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
      errors++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_char(serial_char, start_req);
        accepted_reqs++;
      end
      if (!in_valid || in_ready) begin
        if (serial_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = serial_reqs.pop_front();
          in_valid    <= 1'b1;
          serial_char <= next_req.ch;
          start_req   <= next_req.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_digits.size() == 0) begin
          $display("%0t: unexpected result, expected none actual check_char %0d verdict %0b",
                   $time, check_char, is_verdict);
          errors++;
        end else begin
          want = awaited_digits.pop_front();
          compare_field("check_char", want.check_char, check_char);
          compare_field("group_index", want.group_index, group_index);
          compare_field("is_verdict", want.is_verdict, is_verdict);
          compare_field("match", want.match, match);
          compare_field("last", want.last, last);
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver stall while requests keep coming
  initial begin
    wait (accepted_reqs >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int   unit_items;
    int   r;
    int   n;
    logic vmode;
    serial_pos = '0;
    group_crc  = CRC_SEED;
    digit_miss = 1'b0;
    model_mode = MODE_GENERATE;
    foreach (group_digit[i]) group_digit[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // generate from reset with extreme bytes, then one char past the body
    for (int i = 0; i < BODY_CHARS; i++)
      serial_reqs.push_back('{ch: EDGE_BODY[CHAR_W*(BODY_CHARS-1-i) +: CHAR_W],
                              first: (i == 0)});
    serial_reqs.push_back('{ch: 8'hA5, first: 1'b0});
    wait_drained();

    // switch to verify at the end of the body, then one char past the verdict
    write_mode(MODE_VERIFY);
    for (int k = 0; k < GROUPS; k++)
      serial_reqs.push_back('{ch: CHAR_W'(ASCII_ZERO + group_digit[k]), first: 1'b0});
    serial_reqs.push_back('{ch: 8'h5A, first: 1'b0});
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      vmode = p[0];
      write_mode(vmode);
      case (p / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      unit_items = 0;
      while (unit_items < 100) begin
        r = $urandom_range(99);
        if (r < 70) begin
          queue_serial(BODY_CHARS, vmode ? GROUPS : 0, $urandom_range(1), 0);
          unit_items += vmode ? SERIAL_CHARS : BODY_CHARS;
        end else if (r < 80) begin
          n = $urandom_range(1, BODY_CHARS - 1);
          queue_serial(n, 0, 1'b0, 0);
          unit_items += n;
        end else if (r < 88) begin
          n = $urandom_range(GROUPS);
          queue_serial(BODY_CHARS, n, $urandom_range(1), 0);
          unit_items += BODY_CHARS + n;
        end else if (r < 94) begin
          n = $urandom_range(1, 6);
          queue_serial(0, 0, 1'b0, n);
          unit_items += n;
        end else begin
          queue_serial(BODY_CHARS, vmode ? GROUPS : 0, 1'b0, $urandom_range(1, 3));
          unit_items += vmode ? SERIAL_CHARS : BODY_CHARS;
        end
      end
      wait_drained();
    end

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
